FILE: hw/rtl/cgs_pkg.sv
// Shared types, codes and constants for the character-to-glyph segment lookup.
// Used by cgs_ram, cgs_engine and char_to_glyph_segment_lookup_top.
package cgs_pkg;

    // Default sizes of the segment tables and the glyph array.
    localparam int MAX_SEGMENTS_DEF = 256;
    localparam int GLYPH_DEPTH_DEF  = 1024;

    // Stream and configuration port widths.
    localparam int IN_DATA_W  = 112;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Item opcodes carried in tuser.
    localparam logic [1:0] OP_SEG_WR  = 2'd0;
    localparam logic [1:0] OP_WORD_WR = 2'd1;
    localparam logic [1:0] OP_LOOKUP  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_SEG_COUNT   = 2'd0;
    localparam logic [1:0] REG_GLYPH_COUNT = 2'd1;
    localparam logic [1:0] REG_ARRAY_LEN   = 2'd2;

    // Configuration reset values.
    localparam logic [8:0]  SEG_COUNT_RST   = 9'd1;
    localparam logic [15:0] GLYPH_COUNT_RST = 16'd1;
    localparam logic [10:0] ARRAY_LEN_RST   = 11'd0;

    // One entry of the segment memory.
    typedef struct packed {
        logic [15:0] offset;
        logic [15:0] delta;
        logic [15:0] start_code;
        logic [15:0] end_code;
    } seg_entry_t;

    // Configuration registers as seen by the lookup engine.
    typedef struct packed {
        logic [8:0]  seg_count;
        logic [15:0] glyph_count;
        logic [10:0] array_len;
    } cgs_cfg_t;

    // Lookup request from the input side.
    typedef struct packed {
        logic        valid;
        logic [20:0] code;
    } cgs_req_t;

    // Finished lookup handed to the output register.
    typedef struct packed {
        logic        valid;
        logic [15:0] glyph;
    } cgs_res_t;

    // Lookup engine states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_CHECK,
        ST_ADDR,
        ST_WORD,
        ST_FINAL
    } eng_state_t;

    // Address width of a memory with the given depth, at least one bit.
    function automatic int addr_w(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

FILE: hw/rtl/cgs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on cgs_pkg for the address width function.
module cgs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                clk,
    input  logic                                we,
    input  logic [cgs_pkg::addr_w(DEPTH)-1:0]   waddr,
    input  logic [WIDTH-1:0]                    wdata,
    input  logic                                re,
    input  logic [cgs_pkg::addr_w(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]                    rdata
);
    import cgs_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/cgs_engine.sv
// Lookup sequencer: walks the segment memory, forms the glyph array index,
// reads the glyph array and applies delta and glyph count. Depends on cgs_pkg.
module cgs_engine #(
    parameter int MAX_SEGMENTS      = cgs_pkg::MAX_SEGMENTS_DEF,
    parameter int GLYPH_ARRAY_DEPTH = cgs_pkg::GLYPH_DEPTH_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  cgs_pkg::cgs_cfg_t                             cfg,
    input  cgs_pkg::cgs_req_t                             start,
    output logic                                          idle,
    input  logic                                          out_free,
    output logic                                          seg_re,
    output logic [cgs_pkg::addr_w(MAX_SEGMENTS)-1:0]      seg_raddr,
    input  cgs_pkg::seg_entry_t                           seg_q,
    output logic                                          ga_re,
    output logic [cgs_pkg::addr_w(GLYPH_ARRAY_DEPTH)-1:0] ga_raddr,
    input  logic [15:0]                                   ga_q,
    output cgs_pkg::cgs_res_t                             res
);
    import cgs_pkg::*;

    localparam int SEG_AW   = addr_w(MAX_SEGMENTS);
    localparam int GA_AW    = addr_w(GLYPH_ARRAY_DEPTH);
    localparam int SEG_CW   = $clog2(MAX_SEGMENTS + 1);
    localparam int CNT_W    = (SEG_CW > 9) ? SEG_CW : 9;
    localparam int LIM_RAW  = $clog2(GLYPH_ARRAY_DEPTH + 1);
    localparam int LIM_W    = (LIM_RAW > 11) ? LIM_RAW : 11;
    localparam int IDX_BASE = (CNT_W > 16) ? CNT_W : 16;
    localparam int IDX_W    = ((IDX_BASE > LIM_W) ? IDX_BASE : LIM_W) + 3;

    eng_state_t        state_reg, state_next;
    logic [15:0]       code_reg, code_next;
    logic [SEG_CW-1:0] seg_reg, seg_next;
    logic              rd_valid_reg, rd_valid_next;
    logic [SEG_CW-1:0] rd_seg_reg, rd_seg_next;
    seg_entry_t        ent_reg, ent_next;
    logic [IDX_W-1:0]  base_reg, base_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              word_ok_reg, word_ok_next;
    logic [15:0]       g_reg, g_next;

    logic [CNT_W-1:0]  count;
    logic [LIM_W-1:0]  lim;
    logic              issue_ok;
    logic              hit;
    logic              below_start;
    logic [15:0]       diff;
    logic              in_range;
    logic [15:0]       word;
    logic              code_wide;

    // Segment count saturates at the table size; array limit at the array size.
    assign count = (CNT_W'(cfg.seg_count) > CNT_W'(MAX_SEGMENTS)) ?
                   CNT_W'(MAX_SEGMENTS) : CNT_W'(cfg.seg_count);
    assign lim   = (LIM_W'(cfg.array_len) > LIM_W'(GLYPH_ARRAY_DEPTH)) ?
                   LIM_W'(GLYPH_ARRAY_DEPTH) : LIM_W'(cfg.array_len);

    // Search and mapping conditions.
    assign code_wide   = (start.code[20:16] != 5'd0);
    assign issue_ok    = (CNT_W'(seg_reg) < count);
    assign hit         = rd_valid_reg && (code_reg <= seg_q.end_code);
    assign below_start = (code_reg < ent_reg.start_code);
    assign diff        = code_reg - ent_reg.start_code;
    assign in_range    = !idx_reg[IDX_W-1] && (idx_reg < IDX_W'(lim));
    assign word        = word_ok_reg ? ga_q : 16'd0;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start.valid)
                begin
                    state_next = code_wide ? ST_FINAL : ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (hit)
                begin
                    state_next = ST_CHECK;
                end
                else if (!rd_valid_reg && !issue_ok)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_CHECK:
            begin
                if (below_start || (ent_reg.offset == 16'd0))
                begin
                    state_next = ST_FINAL;
                end
                else
                begin
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR:
            begin
                state_next = ST_WORD;
            end
            ST_WORD:
            begin
                state_next = ST_FINAL;
            end
            ST_FINAL:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs: memory reads and the finished result.
    always_comb
    begin
        idle      = (state_reg == ST_IDLE);
        seg_re    = (state_reg == ST_SEARCH) && issue_ok && !hit;
        seg_raddr = seg_reg[SEG_AW-1:0];
        ga_re     = (state_reg == ST_ADDR) && in_range;
        ga_raddr  = idx_reg[GA_AW-1:0];
        res.valid = (state_reg == ST_FINAL) && out_free;
        res.glyph = (g_reg < cfg.glyph_count) ? g_reg : 16'd0;
    end

    // Datapath next values.
    always_comb
    begin
        code_next     = code_reg;
        seg_next      = seg_reg;
        rd_valid_next = rd_valid_reg;
        rd_seg_next   = rd_seg_reg;
        ent_next      = ent_reg;
        base_next     = base_reg;
        idx_next      = idx_reg;
        word_ok_next  = word_ok_reg;
        g_next        = g_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start.valid)
                begin
                    code_next     = start.code[15:0];
                    seg_next      = '0;
                    rd_valid_next = 1'b0;
                    g_next        = 16'd0;
                end
            end
            ST_SEARCH:
            begin
                // One segment read issued per cycle; the previous one is checked.
                rd_valid_next = seg_re;
                if (seg_re)
                begin
                    seg_next    = seg_reg + 1'b1;
                    rd_seg_next = seg_reg;
                end
                if (hit)
                begin
                    ent_next  = seg_q;
                    base_next = IDX_W'(rd_seg_reg) - IDX_W'(count);
                end
            end
            ST_CHECK:
            begin
                if (below_start)
                begin
                    g_next = 16'd0;
                end
                else if (ent_reg.offset == 16'd0)
                begin
                    g_next = code_reg + ent_reg.delta;
                end
                idx_next = base_reg + IDX_W'(ent_reg.offset[15:1]) + IDX_W'(diff);
            end
            ST_ADDR:
            begin
                word_ok_next = in_range;
            end
            ST_WORD:
            begin
                // A zero word means a missing glyph and takes no delta.
                g_next = (word != 16'd0) ? (word + ent_reg.delta) : 16'd0;
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rd_valid_reg <= 1'b0;
            seg_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= rd_valid_next;
            seg_reg      <= seg_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        code_reg    <= code_next;
        rd_seg_reg  <= rd_seg_next;
        ent_reg     <= ent_next;
        base_reg    <= base_next;
        idx_reg     <= idx_next;
        word_ok_reg <= word_ok_next;
        g_reg       <= g_next;
    end

endmodule

FILE: hw/rtl/char_to_glyph_segment_lookup_top.sv
// Top level of the character-to-glyph segment lookup: stream ports,
// configuration registers, segment and glyph memories, output register.
// Depends on cgs_pkg, cgs_ram and cgs_engine.
//
//   Channel   Direction  Signals                    Item
//   s_*       in         tvalid tready tdata tuser  write segment / word, lookup
//   m_*       out        tvalid tready tdata        glyph index of one lookup
//   wr_*      in         wr_en wr_index wr_data     configuration register write
//
// A write item is written into its memory as it is accepted. A lookup holds off
// the next item from its acceptance until the engine is back in idle. The search
// reads one segment per cycle from the segment memory's single read port, over up
// to segment_count segments, followed by the check, the glyph array address, the
// glyph array read, the result handoff and the return to idle. The memories are
// not cleared at reset; the user must write entries before use; no check is made.
// A finished lookup waits in the output register; the next item is accepted
// while it waits, but a further result holds until that register is free.
module char_to_glyph_segment_lookup_top #(
    parameter int MAX_SEGMENTS      = cgs_pkg::MAX_SEGMENTS_DEF,
    parameter int GLYPH_ARRAY_DEPTH = cgs_pkg::GLYPH_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // entry_index, segment_end_code, segment_start_code, segment_delta_value,
    // segment_offset_bytes, glyph_word, character_code
    input  logic [cgs_pkg::IN_DATA_W-1:0]    s_tdata,
    // opcode
    input  logic [cgs_pkg::IN_USER_W-1:0]    s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // glyph_index
    output logic [cgs_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  logic                             wr_en,
    input  logic [cgs_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [cgs_pkg::CFG_DATA_W-1:0]   wr_data
);
    import cgs_pkg::*;

    localparam int SEG_AW = addr_w(MAX_SEGMENTS);
    localparam int GA_AW  = addr_w(GLYPH_ARRAY_DEPTH);

    // Input fields.
    logic [1:0]         in_opcode;
    logic [9:0]         in_entry_index;
    logic [15:0]        in_end_code;
    logic [15:0]        in_start_code;
    logic signed [15:0] in_delta;
    logic [15:0]        in_offset;
    logic [15:0]        in_glyph_word;
    logic [20:0]        in_code;

    logic               in_acc;
    cgs_cfg_t           cfg;
    cgs_req_t           start;
    cgs_res_t           res;
    logic               eng_idle;
    logic               out_free;

    logic [8:0]         seg_count_reg;
    logic [15:0]        glyph_count_reg;
    logic [10:0]        array_len_reg;

    logic               m_tvalid_reg;
    logic [15:0]        m_tdata_reg;

    logic               seg_we;
    seg_entry_t         seg_wdata;
    logic               seg_re;
    logic [SEG_AW-1:0]  seg_raddr;
    seg_entry_t         seg_q;
    logic               ga_we;
    logic               ga_re;
    logic [GA_AW-1:0]   ga_raddr;
    logic [15:0]        ga_q;

    // Unpack the input item.
    assign in_opcode      = s_tuser[1:0];
    assign in_entry_index = s_tdata[9:0];
    assign in_end_code    = s_tdata[25:10];
    assign in_start_code  = s_tdata[41:26];
    assign in_delta       = $signed(s_tdata[57:42]);
    assign in_offset      = s_tdata[73:58];
    assign in_glyph_word  = s_tdata[89:74];
    assign in_code        = s_tdata[110:90];

    // Items are taken whenever the engine is between lookups.
    assign s_tready    = eng_idle;
    assign in_acc      = s_tvalid && s_tready;
    assign start.valid = in_acc && (in_opcode == OP_LOOKUP);
    assign start.code  = in_code;

    // Table writes go straight into the memories; out-of-range writes drop.
    assign seg_we = in_acc && (in_opcode == OP_SEG_WR)
                 && (32'(in_entry_index) < MAX_SEGMENTS);
    assign ga_we  = in_acc && (in_opcode == OP_WORD_WR)
                 && (32'(in_entry_index) < GLYPH_ARRAY_DEPTH);

    assign seg_wdata.offset     = in_offset;
    assign seg_wdata.delta      = $unsigned(in_delta);
    assign seg_wdata.start_code = in_start_code;
    assign seg_wdata.end_code   = in_end_code;

    // Configuration registers.
    assign cfg.seg_count   = seg_count_reg;
    assign cfg.glyph_count = glyph_count_reg;
    assign cfg.array_len   = array_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_count_reg   <= SEG_COUNT_RST;
            glyph_count_reg <= GLYPH_COUNT_RST;
            array_len_reg   <= ARRAY_LEN_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_SEG_COUNT:   seg_count_reg   <= wr_data[8:0];
                REG_GLYPH_COUNT: glyph_count_reg <= wr_data;
                REG_ARRAY_LEN:   array_len_reg   <= wr_data[10:0];
                default:
                begin
                end
            endcase
        end
    end

    // Segment tables: end, start, delta and offset side by side.
    cgs_ram #(
        .WIDTH ($bits(seg_entry_t)),
        .DEPTH (MAX_SEGMENTS)
    ) u_seg_ram (
        .clk   (clk),
        .we    (seg_we),
        .waddr (SEG_AW'(in_entry_index)),
        .wdata (seg_wdata),
        .re    (seg_re),
        .raddr (seg_raddr),
        .rdata (seg_q)
    );

    // Glyph array words.
    cgs_ram #(
        .WIDTH (16),
        .DEPTH (GLYPH_ARRAY_DEPTH)
    ) u_glyph_ram (
        .clk   (clk),
        .we    (ga_we),
        .waddr (GA_AW'(in_entry_index)),
        .wdata (in_glyph_word),
        .re    (ga_re),
        .raddr (ga_raddr),
        .rdata (ga_q)
    );

    // Lookup sequencer.
    cgs_engine #(
        .MAX_SEGMENTS      (MAX_SEGMENTS),
        .GLYPH_ARRAY_DEPTH (GLYPH_ARRAY_DEPTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .start     (start),
        .idle      (eng_idle),
        .out_free  (out_free),
        .seg_re    (seg_re),
        .seg_raddr (seg_raddr),
        .seg_q     (seg_q),
        .ga_re     (ga_re),
        .ga_raddr  (ga_raddr),
        .ga_q      (ga_q),
        .res       (res)
    );

    // Output register holds a result until the sink takes it.
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            m_tvalid_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            m_tdata_reg <= res.glyph;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: dv/tb_char_to_glyph_segment_lookup_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for char_to_glyph_segment_lookup_top: segment and
// glyph-array loads, character lookups and register settings, with a built-in
// predictor. Depends on cgs_pkg and the RTL of the lookup block.
module tb_char_to_glyph_segment_lookup_top;

    import cgs_pkg::*;

    // Opcode that the block must ignore.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Quiet cycles before a register write and at the end of the run: one full
    // search over every segment plus the glyph array read, with margin.
    localparam int DRAIN_CYCLES = MAX_SEGMENTS_DEF + 16;

    // One input item, unpacked into its fields.
    typedef struct {
        logic [1:0]  op;
        logic [9:0]  entry_idx;
        logic [15:0] end_code;
        logic [15:0] start_code;
        logic [15:0] delta;
        logic [15:0] offset;
        logic [15:0] word;
        logic [20:0] code;
    } cmap_item_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [IN_USER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  wr_index = '0;
    logic [CFG_DATA_W-1:0] wr_data = '0;

    // Predictor copy of the segment tables, the glyph array and the registers.
    logic [15:0] seg_end_mem [MAX_SEGMENTS_DEF];
    logic [15:0] seg_start_mem [MAX_SEGMENTS_DEF];
    logic [15:0] seg_delta_mem [MAX_SEGMENTS_DEF];
    logic [15:0] seg_offset_mem [MAX_SEGMENTS_DEF];
    logic [15:0] glyph_mem [GLYPH_DEPTH_DEF];
    logic [8:0]  cfg_seg_count = SEG_COUNT_RST;
    logic [15:0] cfg_glyph_count = GLYPH_COUNT_RST;
    logic [10:0] cfg_array_len = ARRAY_LEN_RST;

    // Glyph indexes still to come out, oldest first.
    logic [15:0] glyph_expect_q [$];
    logic [15:0] glyph_expected;
    int          mismatch_count = 0;
    bit          idle_en = 1'b1;
    int          stall_left = 0;

    char_to_glyph_segment_lookup_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always #6 clk = ~clk;

    // Maps one character code with the current tables and registers.
    function automatic logic [15:0] map_char_to_glyph(input logic [20:0] code);
        int          count;
        int          seg;
        int          code_i;
        int          start_i;
        int          ofs_i;
        int          word_idx;
        int          word_lim;
        logic [15:0] g;
        if (code > 21'h00FFFF)
            return 16'd0;
        count = (cfg_seg_count > MAX_SEGMENTS_DEF) ? MAX_SEGMENTS_DEF : cfg_seg_count;
        code_i = code;
        // Linear search for the first segment whose end code covers the code.
        seg = 0;
        while (seg < count && code_i > int'(seg_end_mem[seg]))
            seg++;
        if (seg >= count)
            return 16'd0;
        start_i = seg_start_mem[seg];
        if (code_i < start_i)
            return 16'd0;
        ofs_i = seg_offset_mem[seg];
        if (ofs_i == 0)
        begin
            g = code[15:0] + seg_delta_mem[seg];
        end
        else
        begin
            // Index into the glyph array; anything outside the valid words reads zero.
            word_idx = seg + ofs_i / 2 + (code_i - start_i) - count;
            word_lim = (cfg_array_len > GLYPH_DEPTH_DEF) ? GLYPH_DEPTH_DEF : cfg_array_len;
            g = (word_idx < 0 || word_idx >= word_lim) ? 16'd0 : glyph_mem[word_idx];
            if (g != 16'd0)
                g = g + seg_delta_mem[seg];
        end
        return (g < cfg_glyph_count) ? g : 16'd0;
    endfunction

    // An item of the given opcode with random values in every field.
    function automatic cmap_item_t filler_item(input logic [1:0] op);
        cmap_item_t it;
        it.op = op;
        it.entry_idx = 10'($urandom);
        it.end_code = 16'($urandom);
        it.start_code = 16'($urandom);
        it.delta = 16'($urandom);
        it.offset = 16'($urandom);
        it.word = 16'($urandom);
        it.code = 21'($urandom);
        return it;
    endfunction

    // Glyph array word, zero now and then.
    function automatic logic [15:0] random_word();
        return ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom);
    endfunction

    // Range offset for segment s of n: half direct, else aimed into the valid words,
    // sometimes odd, sometimes giving a negative index, sometimes anything.
    function automatic logic [15:0] make_offset(input int s, input int n);
        int          base;
        int          lim;
        logic [15:0] ofs;
        lim = (cfg_array_len > GLYPH_DEPTH_DEF) ? GLYPH_DEPTH_DEF : cfg_array_len;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: ofs = 16'd0;
            5:             ofs = 16'($urandom);
            6:             ofs = 16'(2 * $urandom_range(1, n - s));
            default:
            begin
                base = $urandom_range(0, (lim > 0) ? lim - 1 : 0);
                ofs = 16'(2 * (n - s + base) + ($urandom_range(0, 5) == 0));
            end
        endcase
        return ofs;
    endfunction

    // Code inside or just around one of the first n_seg segments.
    function automatic logic [20:0] pick_mapped_code(input int n_seg);
        int s;
        int lo;
        int hi;
        int c;
        s = $urandom_range(0, n_seg - 1);
        lo = seg_start_mem[s];
        hi = seg_end_mem[s];
        case ($urandom_range(0, 3))
            0: c = lo + $urandom_range(0, 31);
            1:
            begin
                case ($urandom_range(0, 3))
                    0:       c = lo - 1;
                    1:       c = lo;
                    2:       c = hi;
                    default: c = hi + 1;
                endcase
            end
            default: c = (hi >= lo) ? int'($urandom_range(lo, hi)) : lo;
        endcase
        if (c < 0)
            c = 0;
        return 21'(c);
    endfunction

    // Sends one item and updates the predictor once it is accepted.
    task automatic send_item(input cmap_item_t it);
        int gap;
        if (idle_en && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 14);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= it.op;
        s_tdata <= {1'b0, it.code, it.word, it.offset, it.delta, it.start_code,
                    it.end_code, it.entry_idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        case (it.op)
            OP_SEG_WR:
            begin
                if (it.entry_idx < MAX_SEGMENTS_DEF)
                begin
                    seg_end_mem[it.entry_idx] = it.end_code;
                    seg_start_mem[it.entry_idx] = it.start_code;
                    seg_delta_mem[it.entry_idx] = it.delta;
                    seg_offset_mem[it.entry_idx] = it.offset;
                end
            end
            OP_WORD_WR:
            begin
                if (it.entry_idx < GLYPH_DEPTH_DEF)
                    glyph_mem[it.entry_idx] = it.word;
            end
            OP_LOOKUP: glyph_expect_q.push_back(map_char_to_glyph(it.code));
            default: ;
        endcase
    endtask

    task automatic send_lookup(input logic [20:0] code);
        cmap_item_t it = filler_item(OP_LOOKUP);
        it.code = code;
        send_item(it);
    endtask

    task automatic send_segment(input logic [9:0] idx, input logic [15:0] end_code,
                                input logic [15:0] start_code, input logic [15:0] delta,
                                input logic [15:0] offset);
        cmap_item_t it = filler_item(OP_SEG_WR);
        it.entry_idx = idx;
        it.end_code = end_code;
        it.start_code = start_code;
        it.delta = delta;
        it.offset = offset;
        send_item(it);
    endtask

    task automatic send_word(input logic [9:0] idx, input logic [15:0] word);
        cmap_item_t it = filler_item(OP_WORD_WR);
        it.entry_idx = idx;
        it.word = word;
        send_item(it);
    endtask

    // Waits until the block is idle, then writes all three registers.
    task automatic write_config(input int segs, input int glyphs, input int words);
        s_tvalid <= 1'b0;
        while (glyph_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= REG_SEG_COUNT;
        wr_data <= 16'(segs);
        @(posedge clk);
        wr_index <= REG_GLYPH_COUNT;
        wr_data <= 16'(glyphs);
        @(posedge clk);
        wr_index <= REG_ARRAY_LEN;
        wr_data <= 16'(words);
        @(posedge clk);
        wr_en <= 1'b0;
        cfg_seg_count = 9'(segs);
        cfg_glyph_count = 16'(glyphs);
        cfg_array_len = 11'(words);
    endtask

    // Loads a well-formed map of n segments: rising end codes, the last one
    // usually 0xFFFF, start codes after the previous end with occasional gaps.
    task automatic load_segment_map(input int n);
        int i;
        int band;
        int prev_end;
        int e;
        int st;
        band = 65536 / n;
        prev_end = -1;
        for (i = 0; i < n; i++)
        begin
            if (i == n - 1)
                e = ($urandom_range(0, 4) == 0) ? 65535 - int'($urandom_range(1, 200)) : 65535;
            else
                e = (i + 1) * band - 1 - int'($urandom_range(0, band / 2));
            st = prev_end + 1;
            if ($urandom_range(0, 3) == 0)
                st = st + int'($urandom_range(0, (e - prev_end) / 2 + 1));
            if (st > 65535)
                st = 65535;
            send_segment(10'(i), 16'(e), 16'(st), 16'($urandom), make_offset(i, n));
            prev_end = e;
        end
    endtask

    // Random mix: mostly lookups inside the loaded map, then stray codes,
    // word and segment rewrites, ignored writes and unused opcodes.
    task automatic send_random_items(input int n_seg, input int total);
        int         k;
        int         pick;
        int         s;
        cmap_item_t it;
        for (k = 0; k < total; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 62 && n_seg > 0)
                send_lookup(pick_mapped_code(n_seg));
            else if (pick < 77)
                send_lookup(($urandom_range(0, 3) == 0) ? 21'($urandom)
                                                         : 21'($urandom_range(0, 16'hFFFF)));
            else if (pick < 88)
                send_word(10'($urandom), random_word());
            else if (pick < 93 && n_seg > 0)
            begin
                s = $urandom_range(0, n_seg - 1);
                send_segment(10'(s), seg_end_mem[s], seg_start_mem[s], 16'($urandom),
                             make_offset(s, n_seg));
            end
            else if (pick < 97)
            begin
                // Mostly beyond the segment tables, where the write must be dropped.
                it = filler_item(OP_SEG_WR);
                if ($urandom_range(0, 3) != 0)
                    it.entry_idx = 10'($urandom_range(MAX_SEGMENTS_DEF, 1023));
                send_item(it);
            end
            else
                send_item(filler_item(OP_UNUSED));
        end
    endtask

    // Every glyph array word gets written before any lookup; each test loads
    // the segments it searches before its first lookup.
    task automatic test_memory_fill();
        int i;
        for (i = 0; i < GLYPH_DEPTH_DEF; i++)
            send_word(10'(i), random_word());
    endtask

    // Hand-built four-segment map that hits each corner of the mapping.
    task automatic test_special_cases();
        write_config(4, 60000, 16);
        send_segment(10'd0, 16'h0040, 16'h0020, 16'hFFF0, 16'd0);
        send_segment(10'd1, 16'h0100, 16'h0041, 16'd5, 16'd7);
        send_segment(10'd2, 16'h8000, 16'h0200, 16'd0, 16'd2);
        send_segment(10'd3, 16'hFFFE, 16'h9000, 16'h7000, 16'd0);
        send_word(10'd0, 16'd0);
        send_word(10'd1, 16'd100);
        send_word(10'd2, 16'd59999);
        send_word(10'd15, 16'hFFFE);
        // Writes past the segment tables must not alias onto segment 0.
        send_segment(10'd256, 16'hFFFF, 16'h0000, 16'h1234, 16'd0);
        send_segment(10'd768, 16'hFFFF, 16'h0000, 16'h4321, 16'd0);
        send_item(filler_item(OP_UNUSED));
        send_lookup(21'h00010);   // below the start of segment 0
        send_lookup(21'h00030);   // direct map with a negative delta
        send_lookup(21'h00041);   // glyph array word of zero stays zero
        send_lookup(21'h00042);   // array word plus delta
        send_lookup(21'h00043);   // array word plus delta reaches glyph_count
        send_lookup(21'h00050);   // array word plus delta wraps
        send_lookup(21'h00051);   // index past the valid words
        send_lookup(21'h00150);   // between segments
        send_lookup(21'h00200);   // negative array index
        send_lookup(21'h00202);   // array word with a delta of zero
        send_lookup(21'h09000);   // direct map wraps to zero
        send_lookup(21'h09005);   // direct map wraps to a small glyph
        send_lookup(21'h0FFFF);   // no segment covers the code
        send_lookup(21'h10000);   // first code above the 16-bit range
        send_lookup(21'h1FFFFF);  // largest code
    endtask

    // With no segments in use every lookup misses.
    task automatic test_empty_segment_map();
        write_config(0, 16'hFFFF, 1024);
        send_random_items(0, 40);
    endtask

    // Glyph counts of one and zero clip every result to zero.
    task automatic test_glyph_count_limits();
        write_config(1, 1, 0);
        load_segment_map(1);
        send_random_items(1, 40);
        write_config(3, 0, 1024);
        load_segment_map(3);
        send_random_items(3, 40);
    endtask

    // Segment count above the table size saturates; then the full table exactly.
    task automatic test_segment_saturation();
        write_config(511, 16'hFFFF, 2047);
        load_segment_map(MAX_SEGMENTS_DEF);
        send_random_items(MAX_SEGMENTS_DEF, 40);
        write_config(MAX_SEGMENTS_DEF, 40000, 1024);
        send_random_items(MAX_SEGMENTS_DEF, 40);
    endtask

    // Random maps of small sizes; the last one runs with no idling.
    task automatic test_random_maps();
        int p;
        int segs;
        for (p = 0; p < 4; p++)
        begin
            idle_en = (p != 3);
            segs = (p == 1) ? 16 : (p == 2) ? 32 : $urandom_range(1, 32);
            write_config(segs, (p == 0) ? 16'hFFFF : $urandom_range(16'h4000, 16'hFFFF),
                         (p == 0) ? 1024 : $urandom_range(0, 2047));
            load_segment_map(segs);
            send_random_items(segs, 40);
        end
    endtask

    // Result side: random stall bursts on tready.
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            m_tready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else if (idle_en && $urandom_range(0, 7) == 0)
        begin
            m_tready <= 1'b0;
            stall_left = $urandom_range(1, 14) - 1;
        end
        else
            m_tready <= 1'b1;
    end

    // Each accepted result is compared with the oldest expected glyph index.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (glyph_expect_q.size() == 0)
            begin
                $display("%0t: unexpected item, expected none, actual glyph_index %0d",
                         $time, m_tdata);
                mismatch_count++;
            end
            else
            begin
                glyph_expected = glyph_expect_q.pop_front();
                if (m_tdata !== glyph_expected)
                begin
                    $display("%0t: glyph_index mismatch, expected %0d, actual %0d",
                             $time, glyph_expected, m_tdata);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_memory_fill();
        test_special_cases();
        test_empty_segment_map();
        test_glyph_count_limits();
        test_segment_saturation();
        test_random_maps();
        s_tvalid <= 1'b0;
        while (glyph_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && glyph_expect_q.size() == 0)
            $display("[char_to_glyph_segment_lookup_top] OK");
        else
            $display("[char_to_glyph_segment_lookup_top] ERROR");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #60_000_000;
        $display("[char_to_glyph_segment_lookup_top] ERROR");
        $finish;
    end

endmodule
